[hw/rtl/pfs_pkg.sv]
// pfs_pkg: widths, register indexes and reset values for the fitness statistics block
`default_nettype none

package pfs_pkg;

   // fixed field widths of the result item
   localparam int OUT_W  = 24;
   localparam int SD_W   = 23;
   localparam int IDX_W  = 10;
   localparam int BS_W   = 11;
   localparam int NODE_W = 8;

   // configuration registers
   localparam int GS_W       = 11;
   localparam int WC_W       = 8;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 1;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_GROUP_SIZE   = 1'd0;
   localparam csr_index_type CSR_WORKER_COUNT = 1'd1;

   localparam logic [GS_W-1:0] GROUP_SIZE_RST   = 11'd16;
   localparam logic [WC_W-1:0] WORKER_COUNT_RST = 8'd4;

endpackage : pfs_pkg

`default_nettype wire

[hw/rtl/population_fitness_statistics.sv]
// population_fitness_statistics: batch min, max, mean, deviation and best tracking
`default_nettype none

// channel   dir  handshake               payload
// req       in   req_valid / req_stall   req_fitness, req_last
// rsp       out  rsp_valid / rsp_stall   min, max, mean, std_dev, best, improved, index,
//                                        node, batch size
// csr       in   csr_wr_en               csr_index, csr_wr_data
//
// An item passes accept, square and accumulate steps; req_stall is low only while idle.
// A batch end runs the mean and mean square divisions, the variance (again if negative), the
// root and, for an improved best with a nonzero group size, the node division; one shared
// subtractor yields one quotient or root bit per cycle for these divisions and the root.
// Synchronous reset clears the batch; best fitness and config registers get reset values.
// A result waits in the output register while rsp_stall is high; the next batch runs
// meanwhile and only its own result waits for that register to free up.

module population_fitness_statistics #(
   parameter int POP_MAX   = 1024,
   parameter int FIT_WIDTH = 24
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // item input
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [FIT_WIDTH-1:0]         req_fitness,
   input  wire logic                                req_last,
   // result output
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [pfs_pkg::OUT_W-1:0]         rsp_min_fitness,
   output logic signed [pfs_pkg::OUT_W-1:0]         rsp_max_fitness,
   output logic signed [pfs_pkg::OUT_W-1:0]         rsp_mean_fitness,
   output logic        [pfs_pkg::SD_W-1:0]          rsp_std_dev,
   output logic signed [pfs_pkg::OUT_W-1:0]         rsp_best_fitness_out,
   output logic                                     rsp_improved,
   output logic        [pfs_pkg::IDX_W-1:0]         rsp_best_index,
   output logic        [pfs_pkg::NODE_W-1:0]        rsp_best_node_out,
   output logic        [pfs_pkg::BS_W-1:0]          rsp_batch_size,
   // configuration
   input  wire logic                                csr_wr_en,
   input  wire pfs_pkg::csr_index_type              csr_index,
   input  wire logic   [pfs_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   import pfs_pkg::*;

   localparam int CNT_W  = $clog2(POP_MAX + 1);
   localparam int SUM_W  = FIT_WIDTH + CNT_W;
   localparam int P_W    = 2 * FIT_WIDTH - 1;
   localparam int SQ_W   = P_W + CNT_W;
   localparam int Q_W    = SQ_W;
   localparam int ALU_W  = P_W;
   localparam int STEP_W = $clog2(Q_W);

   localparam logic signed [FIT_WIDTH-1:0] FIT_TOP = {1'b0, {(FIT_WIDTH-1){1'b1}}};
   localparam logic [CNT_W-1:0]            CNT_END = CNT_W'(POP_MAX);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_MEAN_DIV,
      ST_SQ_DIV,
      ST_MEAN_SQ,
      ST_VAR,
      ST_VAR_NEG,
      ST_ROOT,
      ST_NODE_DIV,
      ST_EMIT
   } state_type;

   // sequencer and config
   state_type                   state_ff, state_in;
   logic [GS_W-1:0]             group_size_ff, group_size_in;
   logic [WC_W-1:0]             worker_count_ff, worker_count_in;

   // captured item
   logic signed [FIT_WIDTH-1:0] fit_ff, fit_in;
   logic                        last_ff, last_in;

   // batch accumulators
   logic signed [FIT_WIDTH-1:0] min_ff, min_in;
   logic signed [FIT_WIDTH-1:0] max_ff, max_in;
   logic signed [SUM_W-1:0]     sum_ff, sum_in;
   logic [SQ_W-1:0]             sq_ff, sq_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        improved_ff, improved_in;

   // best across batches
   logic signed [FIT_WIDTH-1:0] best_ff, best_in;
   logic [IDX_W-1:0]            best_idx_ff, best_idx_in;
   logic [NODE_W-1:0]           best_node_ff, best_node_in;

   // end of batch working registers
   logic [P_W-1:0]              prod_ff, prod_in;
   logic [Q_W-1:0]              q_ff, q_in;
   logic [GS_W-1:0]             rem_ff, rem_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic                        neg_ff, neg_in;
   logic signed [FIT_WIDTH-1:0] mean_ff, mean_in;
   logic [P_W-1:0]              msq_ff, msq_in;
   logic [P_W-1:0]              var_ff, var_in;
   logic [P_W-1:0]              root_ff, root_in;
   logic [P_W-1:0]              bit_ff, bit_in;
   logic [SD_W-1:0]             sd_ff, sd_in;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]     o_min_ff, o_min_in;
   logic signed [OUT_W-1:0]     o_max_ff, o_max_in;
   logic signed [OUT_W-1:0]     o_mean_ff, o_mean_in;
   logic [SD_W-1:0]             o_sd_ff, o_sd_in;
   logic signed [OUT_W-1:0]     o_best_ff, o_best_in;
   logic                        o_improved_ff, o_improved_in;
   logic [IDX_W-1:0]            o_idx_ff, o_idx_in;
   logic [NODE_W-1:0]           o_node_ff, o_node_in;
   logic [BS_W-1:0]             o_bs_ff, o_bs_in;

   // shared datapath
   logic signed [FIT_WIDTH-1:0]   mul_op;
   logic signed [2*FIT_WIDTH-1:0] mul_full;
   logic [ALU_W-1:0]              alu_a, alu_b, alu_res;
   logic [ALU_W:0]                alu_diff;
   logic                          alu_ge;
   logic [GS_W:0]                 div_trial;
   logic [GS_W-1:0]               div_divisor;
   logic [Q_W-1:0]                div_q;
   logic [GS_W-1:0]               div_rem;
   logic [P_W-1:0]                root_next;
   logic [SUM_W-1:0]              sum_mag;
   logic [FIT_WIDTH-1:0]          mean_mag;
   logic [IDX_W:0]                node_calc;

   // shared multiplier: item square or square of the mean
   always_comb begin
      mul_op   = (state_ff == ST_MEAN_SQ) ? mean_ff : fit_ff;
      mul_full = mul_op * mul_op;
   end

   // division step operands
   always_comb begin
      div_trial   = {rem_ff, q_ff[Q_W-1]};
      div_divisor = (state_ff == ST_NODE_DIV) ? group_size_ff : GS_W'(count_ff);
   end

   // shared subtract and compare unit
   always_comb begin
      unique case (state_ff)
         ST_MEAN_DIV, ST_SQ_DIV, ST_NODE_DIV: begin
            alu_a = ALU_W'(div_trial);
            alu_b = ALU_W'(div_divisor);
         end
         ST_VAR: begin
            alu_a = msq_ff;
            alu_b = prod_ff;
         end
         ST_VAR_NEG: begin
            alu_a = prod_ff;
            alu_b = msq_ff;
         end
         ST_ROOT: begin
            alu_a = var_ff;
            alu_b = root_ff + bit_ff;
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
      alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
      alu_ge   = ~alu_diff[ALU_W];
      alu_res  = alu_diff[ALU_W-1:0];
   end

   // step results of the shared unit
   always_comb begin
      div_q     = {q_ff[Q_W-2:0], alu_ge};
      div_rem   = alu_ge ? alu_res[GS_W-1:0] : div_trial[GS_W-1:0];
      root_next = alu_ge ? ((root_ff >> 1) + bit_ff) : (root_ff >> 1);
      sum_mag   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      mean_mag  = div_q[FIT_WIDTH-1:0];
      node_calc = {1'b0, div_q[IDX_W-1:0]} + (IDX_W+1)'(1);
   end

   // sequencer and next-state logic
   always_comb begin
      state_in        = state_ff;
      group_size_in   = group_size_ff;
      worker_count_in = worker_count_ff;
      fit_in          = fit_ff;
      last_in         = last_ff;
      min_in          = min_ff;
      max_in          = max_ff;
      sum_in          = sum_ff;
      sq_in           = sq_ff;
      count_in        = count_ff;
      improved_in     = improved_ff;
      best_in         = best_ff;
      best_idx_in     = best_idx_ff;
      best_node_in    = best_node_ff;
      prod_in         = prod_ff;
      q_in            = q_ff;
      rem_in          = rem_ff;
      step_in         = step_ff;
      neg_in          = neg_ff;
      mean_in         = mean_ff;
      msq_in          = msq_ff;
      var_in          = var_ff;
      root_in         = root_ff;
      bit_in          = bit_ff;
      sd_in           = sd_ff;
      rsp_valid_in    = rsp_valid_ff;
      o_min_in        = o_min_ff;
      o_max_in        = o_max_ff;
      o_mean_in       = o_mean_ff;
      o_sd_in         = o_sd_ff;
      o_best_in       = o_best_ff;
      o_improved_in   = o_improved_ff;
      o_idx_in        = o_idx_ff;
      o_node_in       = o_node_ff;
      o_bs_in         = o_bs_ff;

      // config writes
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GROUP_SIZE:   group_size_in   = csr_wr_data[GS_W-1:0];
            CSR_WORKER_COUNT: worker_count_in = csr_wr_data[WC_W-1:0];
            default:          ;
         endcase
      end

      // output register drains
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               fit_in   = req_fitness;
               last_in  = req_last;
               state_in = ST_MUL;
            end
         end

         // square, extremes, sum and best
         ST_MUL: begin
            prod_in = mul_full[P_W-1:0];
            if (count_ff == '0 || fit_ff < min_ff) begin
               min_in = fit_ff;
            end
            if (count_ff == '0 || fit_ff > max_ff) begin
               max_in = fit_ff;
            end
            sum_in = sum_ff + SUM_W'(fit_ff);
            if (fit_ff < best_ff) begin
               best_in     = fit_ff;
               best_idx_in = IDX_W'(count_ff);
               improved_in = 1'b1;
            end
            count_in = count_ff + CNT_W'(1);
            state_in = ST_ADD;
         end

         // square accumulation and end of batch check
         ST_ADD: begin
            sq_in = sq_ff + SQ_W'(prod_ff);
            if (last_ff || count_ff == CNT_END) begin
               q_in     = {sum_mag, {(Q_W-SUM_W){1'b0}}};
               rem_in   = '0;
               neg_in   = sum_ff[SUM_W-1];
               step_in  = STEP_W'(SUM_W - 1);
               state_in = ST_MEAN_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end

         // mean magnitude, one quotient bit a cycle
         ST_MEAN_DIV: begin
            q_in    = div_q;
            rem_in  = div_rem;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               mean_in  = neg_ff ? -mean_mag : mean_mag;
               q_in     = sq_ff;
               rem_in   = '0;
               step_in  = STEP_W'(Q_W - 1);
               state_in = ST_SQ_DIV;
            end
         end

         // mean square
         ST_SQ_DIV: begin
            q_in    = div_q;
            rem_in  = div_rem;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               msq_in   = div_q[P_W-1:0];
               state_in = ST_MEAN_SQ;
            end
         end

         ST_MEAN_SQ: begin
            prod_in  = mul_full[P_W-1:0];
            state_in = ST_VAR;
         end

         // absolute variance, second pass when negative
         ST_VAR: begin
            if (alu_ge) begin
               var_in   = alu_res;
               root_in  = '0;
               bit_in   = {1'b1, {(P_W-1){1'b0}}};
               step_in  = STEP_W'(FIT_WIDTH - 1);
               state_in = ST_ROOT;
            end else begin
               state_in = ST_VAR_NEG;
            end
         end

         ST_VAR_NEG: begin
            var_in   = alu_res;
            root_in  = '0;
            bit_in   = {1'b1, {(P_W-1){1'b0}}};
            step_in  = STEP_W'(FIT_WIDTH - 1);
            state_in = ST_ROOT;
         end

         // square root, one result bit a cycle
         ST_ROOT: begin
            if (alu_ge) begin
               var_in = alu_res;
            end
            root_in = root_next;
            bit_in  = bit_ff >> 2;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               if (root_next[P_W-1:FIT_WIDTH-1] != '0) begin
                  sd_in = SD_W'(FIT_TOP);
               end else begin
                  sd_in = SD_W'(root_next[FIT_WIDTH-2:0]);
               end
               if (improved_ff && group_size_ff != '0) begin
                  q_in     = {best_idx_ff, {(Q_W-IDX_W){1'b0}}};
                  rem_in   = '0;
                  step_in  = STEP_W'(IDX_W - 1);
                  state_in = ST_NODE_DIV;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end

         // source node of the best
         ST_NODE_DIV: begin
            q_in    = div_q;
            rem_in  = div_rem;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               if (node_calc <= (IDX_W+1)'(worker_count_ff)) begin
                  best_node_in = node_calc[NODE_W-1:0];
               end
               state_in = ST_EMIT;
            end
         end

         // load output register and clear the batch
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               o_min_in      = OUT_W'(min_ff);
               o_max_in      = OUT_W'(max_ff);
               o_mean_in     = OUT_W'(mean_ff);
               o_sd_in       = sd_ff;
               o_best_in     = OUT_W'(best_ff);
               o_improved_in = improved_ff;
               o_idx_in      = best_idx_ff;
               o_node_in     = best_node_ff;
               o_bs_in       = BS_W'(count_ff);
               min_in        = '0;
               max_in        = '0;
               sum_in        = '0;
               sq_in         = '0;
               count_in      = '0;
               improved_in   = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // state, accumulators and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         group_size_ff   <= GROUP_SIZE_RST;
         worker_count_ff <= WORKER_COUNT_RST;
         min_ff          <= '0;
         max_ff          <= '0;
         sum_ff          <= '0;
         sq_ff           <= '0;
         count_ff        <= '0;
         improved_ff     <= 1'b0;
         best_ff         <= FIT_TOP;
         best_idx_ff     <= '0;
         best_node_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         group_size_ff   <= group_size_in;
         worker_count_ff <= worker_count_in;
         min_ff          <= min_in;
         max_ff          <= max_in;
         sum_ff          <= sum_in;
         sq_ff           <= sq_in;
         count_ff        <= count_in;
         improved_ff     <= improved_in;
         best_ff         <= best_in;
         best_idx_ff     <= best_idx_in;
         best_node_ff    <= best_node_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      fit_ff        <= fit_in;
      last_ff       <= last_in;
      prod_ff       <= prod_in;
      q_ff          <= q_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      neg_ff        <= neg_in;
      mean_ff       <= mean_in;
      msq_ff        <= msq_in;
      var_ff        <= var_in;
      root_ff       <= root_in;
      bit_ff        <= bit_in;
      sd_ff         <= sd_in;
      o_min_ff      <= o_min_in;
      o_max_ff      <= o_max_in;
      o_mean_ff     <= o_mean_in;
      o_sd_ff       <= o_sd_in;
      o_best_ff     <= o_best_in;
      o_improved_ff <= o_improved_in;
      o_idx_ff      <= o_idx_in;
      o_node_ff     <= o_node_in;
      o_bs_ff       <= o_bs_in;
   end

   // ports
   assign req_stall            = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_min_fitness      = o_min_ff;
   assign rsp_max_fitness      = o_max_ff;
   assign rsp_mean_fitness     = o_mean_ff;
   assign rsp_std_dev          = o_sd_ff;
   assign rsp_best_fitness_out = o_best_ff;
   assign rsp_improved         = o_improved_ff;
   assign rsp_best_index       = o_idx_ff;
   assign rsp_best_node_out    = o_node_ff;
   assign rsp_batch_size       = o_bs_ff;

endmodule : population_fitness_statistics

`default_nettype wire

[tb/testbench.sv]
// testbench for population_fitness_statistics: directed and random batches, scoreboard checking
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pfs_pkg::*;

   localparam int FIT_W          = 24;
   localparam int POP_LIMIT      = 1024;
   localparam int FIT_TOP        = 8388607;
   localparam int SETTLE_CYCLES  = 200;
   localparam int WATCHDOG_LIMIT = 5000;

   // one result item of the block
   typedef struct {
      logic signed [OUT_W-1:0] min_f;
      logic signed [OUT_W-1:0] max_f;
      logic signed [OUT_W-1:0] mean_f;
      logic [SD_W-1:0]         sd;
      logic signed [OUT_W-1:0] best;
      logic                    improved;
      logic [IDX_W-1:0]        index;
      logic [NODE_W-1:0]       node;
      logic [BS_W-1:0]         size;
   } batch_stats_type;

   // batch statistics predictor and expected result store
   class fitness_stats_board_type;
      logic [GS_W-1:0]          grp_size;
      logic [WC_W-1:0]          workers;
      logic signed [FIT_W-1:0]  run_min;
      logic signed [FIT_W-1:0]  run_max;
      longint                   sum;
      longint unsigned          sq_sum;
      int                       count;
      logic signed [FIT_W-1:0]  best;
      logic [IDX_W-1:0]         best_idx;
      logic                     improved;
      logic [NODE_W-1:0]        node;
      batch_stats_type          expected_stats[$];
      int                       mismatch_count;

      function new();
         grp_size = GROUP_SIZE_RST;
         workers = WORKER_COUNT_RST;
         best = FIT_W'(FIT_TOP);
         best_idx = '0;
         node = '0;
         mismatch_count = 0;
         clear_batch();
      endfunction

      function void clear_batch();
         run_min = '0;
         run_max = '0;
         sum = 0;
         sq_sum = 0;
         count = 0;
         improved = 1'b0;
      endfunction

      function void set_config(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_GROUP_SIZE:   grp_size = value[GS_W-1:0];
            CSR_WORKER_COUNT: workers = value[WC_W-1:0];
            default: ;
         endcase
      endfunction

      // floor of the square root, one result bit at a time
      function longint unsigned floor_root(longint unsigned v);
         longint unsigned root;
         longint unsigned trial;
         root = 0;
         for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
         end
         return root;
      endfunction

      // accepted fitness item: update the batch and the best, predict the batch result
      function void add_fitness(logic signed [FIT_W-1:0] f, logic last_flag);
         longint          fv;
         longint          mean;
         longint          spread;
         longint unsigned msq;
         longint unsigned root;
         longint unsigned cand;
         batch_stats_type r;
         fv = longint'(f);
         if (count == 0) begin
            run_min = f;
            run_max = f;
         end
         if (f > run_max) run_max = f;
         if (f < run_min) run_min = f;
         sum += fv;
         sq_sum += longint'(fv * fv);
         if (f < best) begin
            best = f;
            best_idx = count[IDX_W-1:0];
            improved = 1'b1;
         end
         count++;
         if (!last_flag && count < POP_LIMIT) return;

         mean = sum / longint'(count);
         msq = sq_sum / longint'(count);
         spread = longint'(msq) - mean * mean;
         if (spread < 0) spread = -spread;
         root = floor_root(spread);
         if (root > FIT_TOP) root = 64'(FIT_TOP);
         // node of the best only moves when it lands within the worker range
         if (improved && grp_size != 0) begin
            cand = longint'(best_idx) / longint'(grp_size) + 1;
            if (cand <= longint'(workers)) node = cand[NODE_W-1:0];
         end
         r.min_f = run_min;
         r.max_f = run_max;
         r.mean_f = mean[OUT_W-1:0];
         r.sd = root[SD_W-1:0];
         r.best = best;
         r.improved = improved;
         r.index = best_idx;
         r.node = node;
         r.size = count[BS_W-1:0];
         expected_stats.push_back(r);
         clear_batch();
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
         end
      endfunction

      // accepted result item against the oldest expectation
      function void check_batch_stats(batch_stats_type got);
         batch_stats_type want;
         if (expected_stats.size() == 0) begin
            $display("%0t: unexpected result, expected none actual batch_size %0d",
                     $time, got.size);
            mismatch_count++;
            return;
         end
         want = expected_stats.pop_front();
         compare_field("min_fitness", longint'(want.min_f), longint'(got.min_f));
         compare_field("max_fitness", longint'(want.max_f), longint'(got.max_f));
         compare_field("mean_fitness", longint'(want.mean_f), longint'(got.mean_f));
         compare_field("std_dev", longint'(want.sd), longint'(got.sd));
         compare_field("best_fitness_out", longint'(want.best), longint'(got.best));
         compare_field("improved", longint'(want.improved), longint'(got.improved));
         compare_field("best_index", longint'(want.index), longint'(got.index));
         compare_field("best_node_out", longint'(want.node), longint'(got.node));
         compare_field("batch_size", longint'(want.size), longint'(got.size));
      endfunction

      function int pending();
         return expected_stats.size();
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [FIT_W-1:0]       req_fitness = '0;
   logic                          req_last = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [OUT_W-1:0]       rsp_min_fitness;
   logic signed [OUT_W-1:0]       rsp_max_fitness;
   logic signed [OUT_W-1:0]       rsp_mean_fitness;
   logic [SD_W-1:0]               rsp_std_dev;
   logic signed [OUT_W-1:0]       rsp_best_fitness_out;
   logic                          rsp_improved;
   logic [IDX_W-1:0]              rsp_best_index;
   logic [NODE_W-1:0]             rsp_best_node_out;
   logic [BS_W-1:0]               rsp_batch_size;
   logic                          csr_wr_en = 1'b0;
   csr_index_type                 csr_index = CSR_GROUP_SIZE;
   logic [CSR_DATA_W-1:0]         csr_wr_data = '0;

   fitness_stats_board_type stats = new();
   bit  quiet = 1'b0;
   int  level;
   int  idle_cycles = 0;
   int  stall_left = 0;

   population_fitness_statistics #(
      .POP_MAX   (POP_LIMIT),
      .FIT_WIDTH (FIT_W)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_fitness          (req_fitness),
      .req_last             (req_last),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_min_fitness      (rsp_min_fitness),
      .rsp_max_fitness      (rsp_max_fitness),
      .rsp_mean_fitness     (rsp_mean_fitness),
      .rsp_std_dev          (rsp_std_dev),
      .rsp_best_fitness_out (rsp_best_fitness_out),
      .rsp_improved         (rsp_improved),
      .rsp_best_index       (rsp_best_index),
      .rsp_best_node_out    (rsp_best_node_out),
      .rsp_batch_size       (rsp_batch_size),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wr_data          (csr_wr_data)
   );

   always #5 clock = ~clock;

   // result side: check accepted items, then stall at random, counting down only while a result is valid
   always @(posedge clock) begin
      batch_stats_type got;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.min_f = rsp_min_fitness;
            got.max_f = rsp_max_fitness;
            got.mean_f = rsp_mean_fitness;
            got.sd = rsp_std_dev;
            got.best = rsp_best_fitness_out;
            got.improved = rsp_improved;
            got.index = rsp_best_index;
            got.node = rsp_best_node_out;
            got.size = rsp_batch_size;
            stats.check_batch_stats(got);
            stall_left = quiet ? 0 : $urandom_range(0, 10);
         end else if (rsp_valid && stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // one fitness item, with a random gap ahead of it unless quiet
   task automatic send_fitness(input logic signed [FIT_W-1:0] f, input logic last_flag);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_fitness <= f;
      req_last <= last_flag;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      stats.add_fitness(f, last_flag);
   endtask

   // batch of values around a level that drifts down when drift is set, with noise above it
   task automatic run_batch(input int len, input bit drift);
      int f;
      for (int i = 0; i < len; i++) begin
         if (drift) begin
            level -= int'($urandom_range(0, 40000));
            if (level < -8350000) level = -8350000;
         end
         if ($urandom_range(0, 4) != 0)
            f = level + int'($urandom_range(0, 60000)) - 30000;
         else
            f = level + int'($urandom_range(0, FIT_TOP - level));
         if (f > FIT_TOP) f = FIT_TOP;
         if (f < -FIT_TOP - 1) f = -FIT_TOP - 1;
         send_fitness(f[FIT_W-1:0], i == len - 1);
      end
   endtask

   // let every expected result arrive and the block go quiet
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (stats.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input int gs, input int wc);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_GROUP_SIZE;
      csr_wr_data <= gs[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index <= CSR_WORKER_COUNT;
      csr_wr_data <= wc[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      stats.set_config(CSR_GROUP_SIZE, gs[CSR_DATA_W-1:0]);
      stats.set_config(CSR_WORKER_COUNT, wc[CSR_DATA_W-1:0]);
   endtask

   initial begin
      int gs;
      int wc;
      int budget;
      int sent;
      int len;
      int pick;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: largest value never becomes the best
      send_fitness(24'sh7FFFFF, 1'b1);
      // first improvement at index 0
      send_fitness(24'sd0, 1'b1);
      // flat batch, no improvement, stored index shown
      send_fitness(24'sd5, 1'b0);
      send_fitness(24'sd5, 1'b1);
      // minus one in Q16.8 at index 1, mixed with the top value
      send_fitness(24'sd100, 1'b0);
      send_fitness(-24'sd256, 1'b0);
      send_fitness(24'sh7FFFFF, 1'b1);
      // best deep in the batch lands on the second node
      for (int i = 0; i < 18; i++)
         send_fitness((i == 17) ? -24'sd300 : 24'(1000 + i), i == 17);

      // random phases across register settings
      level = -400;
      for (int p = 0; p < 6; p++) begin
         settle_idle();
         quiet = 1'b0;
         budget = 125;
         case (p)
            0: begin gs = 1;    wc = 1;   end
            1: begin gs = 1024; wc = 255; end
            2: begin gs = 3;    wc = 255; end
            3: begin gs = $urandom_range(1, 8); wc = $urandom_range(1, 20); end
            4: begin gs = 7;    wc = 2;   quiet = 1'b1; end
            default: begin gs = 2; wc = 10; budget = 1040; end
         endcase
         apply_settings(gs, wc);
         sent = 0;
         // oversized batch: the item that fills the population ends it early
         if (p == 5) begin
            run_batch(POP_LIMIT + 6, 1'b0);
            sent = POP_LIMIT + 6;
         end
         while (sent < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) len = $urandom_range(1, 12);
            else if (pick < 95) len = $urandom_range(13, 60);
            else len = $urandom_range(61, 200);
            run_batch(len, $urandom_range(0, 1));
            sent += len;
         end
      end

      // closing batch at the negative extreme with the widest spread
      settle_idle();
      quiet = 1'b0;
      apply_settings(16, 4);
      send_fitness(24'sh800000, 1'b0);
      send_fitness(24'sh7FFFFF, 1'b0);
      send_fitness(24'sh800000, 1'b0);
      send_fitness(24'sh7FFFFF, 1'b1);

      settle_idle();
      if (stats.mismatch_count == 0 && stats.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
